[hdl/mspm_pkg.sv]
// Shared types and constants for the stereo PCM mixer.
`default_nettype none
package mspm_pkg;

  // Voice count and width of the per-voice sample counters
  localparam int VOICES      = 16;
  localparam int LENGTH_BITS = 20;
  localparam int VOICE_W     = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Gain arithmetic
  localparam logic [15:0] DIVISOR_RESET = 16'd16129;
  localparam logic [7:0]  PAN_FULL      = 8'd254;
  localparam logic [7:0]  GAIN_MAX      = 8'd255;

  // Serial divider: dividend is volume (7 bits) times pan fraction (8 bits)
  localparam int DIVIDEND_W = 15;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_MIX    = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic mix_step;
    logic apply;
    logic out_load;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic voice_ok;
    logic div_busy;
    logic last_voice;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/mspm_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mspm_div
  import mspm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [15:0]           divisor,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic                  busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] num_r, num_nxt;
  logic [15:0]           rem_r, rem_nxt;
  logic [15:0]           den_r, den_nxt;
  logic [16:0]           shifted;
  logic [17:0]           trial;

  // One trial subtraction per step
  always_comb begin
    shifted  = {rem_r, num_r[DIVIDEND_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W);
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[15:0];
        num_nxt = {num_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        num_nxt = {num_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = num_r;

endmodule
`default_nettype wire

[hdl/mspm_dp.sv]
// Mixer datapath: item registers, voice state, gain dividers and the mix accumulator.
`default_nettype none
module mspm_dp
  import mspm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_ctrl_t    ctrl,
  output dp_status_t       status,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  // input fields
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_voice,
  input  wire logic [19:0] in_sound_length,
  input  wire logic [6:0]  in_volume,
  input  wire logic [7:0]  in_separation,
  input  wire logic [63:0] in_samples_low,
  input  wire logic [63:0] in_samples_high,
  // result fields
  output logic signed [15:0] out_mix_left,
  output logic signed [15:0] out_mix_right,
  output logic [15:0]        out_playing_mask
);

  // Item registers
  cmd_t        cmd_r;
  logic [3:0]  voice_r;
  logic [19:0] length_r;
  logic [6:0]  volume_r;
  logic [7:0]  sep_r;
  logic [127:0] samples_r;

  // Configuration
  logic [15:0] divisor_r;

  // Voice state
  logic [VOICES-1:0]      active_r, active_nxt;
  logic [LENGTH_BITS-1:0] pos_r   [VOICES];
  logic [LENGTH_BITS-1:0] len_r   [VOICES];
  logic [7:0]             gain_l_r [VOICES];
  logic [7:0]             gain_r_r [VOICES];

  // Mix sequencing and sums
  logic [VOICE_W-1:0]  mix_cnt_r;
  logic signed [15:0]  sum_l_r, sum_r_r;
  logic signed [15:0]  sum_l_nxt, sum_r_nxt;

  // Output registers
  logic signed [15:0] out_l_r, out_r_r;
  logic [15:0]        out_mask_r;

  // Gain divider signals
  logic [7:0]            sep_clamp, frac_l;
  logic [DIVIDEND_W-1:0] dividend_l, dividend_r;
  logic [15:0]           divisor_eff;
  logic                  busy_l, busy_rt;
  logic [DIVIDEND_W-1:0] quot_l, quot_r;
  logic [7:0]            gain_l_new, gain_r_new;

  // Per-voice mix signals
  logic [VOICE_W-1:0]     vidx;
  logic [VOICE_W-1:0]     cidx;
  logic                   voice_ok;
  logic                   cur_active, cur_ended;
  logic [7:0]             cur_byte;
  logic signed [16:0]     term_l, term_r;

  // Sample scaled by gain/255, truncated toward zero. The sample is
  // (byte-128)*256, so with p = (byte-128)*gain, p*256/255 = 256*a + r
  // where p = 255*a + r.
  function automatic logic signed [16:0] scale255(input logic [7:0] b, input logic [7:0] g);
    logic signed [8:0]  ds;
    logic signed [17:0] p;
    logic               neg;
    logic [14:0]        mag;
    logic [6:0]         a0;
    logic [8:0]         r0;
    logic [7:0]         a1;
    logic [7:0]         r1;
    logic [15:0]        qmag;
    ds   = $signed({1'b0, b}) - 9'sd128;
    p    = ds * $signed({1'b0, g});
    neg  = p[17];
    mag  = neg ? 15'(-p) : p[14:0];
    a0   = mag[14:8];
    r0   = {1'b0, mag[7:0]} + {2'b00, a0};
    if (r0 >= 9'd255) begin
      a1 = {1'b0, a0} + 8'd1;
      r1 = 8'(r0 - 9'd255);
    end else begin
      a1 = {1'b0, a0};
      r1 = r0[7:0];
    end
    qmag = {a1, 8'h00} + {8'h00, r1};
    scale255 = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  endfunction

  // Add with 16-bit signed saturation
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [16:0] b);
    logic signed [17:0] s;
    s = {{2{a[15]}}, a} + {b[16], b};
    if (s > 18'sd32767) begin
      sat_add = 16'sh7fff;
    end else if (s < -18'sd32768) begin
      sat_add = 16'sh8000;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  // Index and range check of the addressed voice
  assign vidx     = voice_r[VOICE_W-1:0];
  assign voice_ok = ({1'b0, voice_r} < 5'(VOICES));
  assign cidx     = mix_cnt_r;

  // Dividends for the two side gains
  always_comb begin
    sep_clamp   = (sep_r > PAN_FULL) ? PAN_FULL : sep_r;
    frac_l      = PAN_FULL - sep_clamp;
    dividend_l  = DIVIDEND_W'(volume_r * frac_l);
    dividend_r  = DIVIDEND_W'(volume_r * sep_clamp);
    divisor_eff = (divisor_r == 16'd0) ? 16'd1 : divisor_r;
  end

  mspm_div u_div_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (dividend_l),
    .divisor  (divisor_eff),
    .busy     (busy_l),
    .quotient (quot_l)
  );

  mspm_div u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (dividend_r),
    .divisor  (divisor_eff),
    .busy     (busy_rt),
    .quotient (quot_r)
  );

  // Clip quotients to the gain range
  assign gain_l_new = (quot_l > DIVIDEND_W'(GAIN_MAX)) ? GAIN_MAX : quot_l[7:0];
  assign gain_r_new = (quot_r > DIVIDEND_W'(GAIN_MAX)) ? GAIN_MAX : quot_r[7:0];

  // Current voice of the mix pass
  always_comb begin
    cur_active = active_r[cidx];
    cur_ended  = (pos_r[cidx] >= len_r[cidx]);
    cur_byte   = samples_r[cidx*8 +: 8];
    term_l     = scale255(cur_byte, gain_l_r[cidx]);
    term_r     = scale255(cur_byte, gain_r_r[cidx]);
  end

  // Active flags and sums
  always_comb begin
    active_nxt = active_r;
    sum_l_nxt  = sum_l_r;
    sum_r_nxt  = sum_r_r;
    if (ctrl.load_item) begin
      sum_l_nxt = '0;
      sum_r_nxt = '0;
    end else if (ctrl.mix_step) begin
      if (cur_active) begin
        if (cur_ended) begin
          active_nxt[cidx] = 1'b0;
        end else begin
          sum_l_nxt = sat_add(sum_l_r, term_l);
          sum_r_nxt = sat_add(sum_r_r, term_r);
        end
      end
    end else if (ctrl.apply && voice_ok) begin
      if (cmd_r == CMD_START) begin
        active_nxt[vidx] = 1'b1;
      end else if (cmd_r == CMD_STOP) begin
        active_nxt[vidx] = 1'b0;
      end
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIVISOR_RESET;
      active_r  <= '0;
      mix_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        divisor_r <= cfg_wdata;
      end
      active_r <= active_nxt;
      if (ctrl.load_item) begin
        mix_cnt_r <= '0;
      end else if (ctrl.mix_step) begin
        mix_cnt_r <= mix_cnt_r + 1'b1;
      end
    end
  end

  // Item capture, sums and output payload
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cmd_r     <= cmd_t'(in_cmd);
      voice_r   <= in_voice;
      length_r  <= in_sound_length;
      volume_r  <= in_volume;
      sep_r     <= in_separation;
      samples_r <= {in_samples_high, in_samples_low};
    end
    sum_l_r <= sum_l_nxt;
    sum_r_r <= sum_r_nxt;
    if (ctrl.out_load) begin
      out_l_r    <= sum_l_r;
      out_r_r    <= sum_r_r;
      out_mask_r <= 16'(active_r);
    end
  end

  // Per-voice position, length and gain stores
  always_ff @(posedge clk) begin
    if (ctrl.mix_step) begin
      if (cur_active && !cur_ended) begin
        pos_r[cidx] <= pos_r[cidx] + 1'b1;
      end
    end else if (ctrl.apply && voice_ok) begin
      if (cmd_r == CMD_START) begin
        pos_r[vidx]    <= '0;
        len_r[vidx]    <= LENGTH_BITS'(length_r);
        gain_l_r[vidx] <= gain_l_new;
        gain_r_r[vidx] <= gain_r_new;
      end else if (cmd_r == CMD_UPDATE) begin
        gain_l_r[vidx] <= gain_l_new;
        gain_r_r[vidx] <= gain_r_new;
      end
    end
  end

  // Status to the controller
  assign status.cmd        = cmd_r;
  assign status.voice_ok   = voice_ok;
  assign status.div_busy   = busy_l | busy_rt;
  assign status.last_voice = (mix_cnt_r == VOICE_W'(VOICES - 1));

  assign out_mix_left     = out_l_r;
  assign out_mix_right    = out_r_r;
  assign out_playing_mask = out_mask_r;

endmodule
`default_nettype wire

[hdl/mspm_ctrl.sv]
// Mixer controller: command sequencing and the handshakes of both channels.
`default_nettype none
module mspm_ctrl
  import mspm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output dp_ctrl_t        ctrl
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_DECODE = 7'b000_0010,
    S_DSTART = 7'b000_0100,
    S_DWAIT  = 7'b000_1000,
    S_MIX    = 7'b001_0000,
    S_APPLY  = 7'b010_0000,
    S_DONE   = 7'b100_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    ctrl           = '0;
    ctrl.load_item = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.cmd == CMD_MIX) begin
          state_nxt = S_MIX;
        end else if (status.voice_ok &&
                     (status.cmd == CMD_START || status.cmd == CMD_UPDATE)) begin
          state_nxt = S_DSTART;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_DSTART: begin
        ctrl.div_start = 1'b1;
        state_nxt      = S_DWAIT;
      end
      S_DWAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_APPLY;
        end
      end
      S_MIX: begin
        ctrl.mix_step = 1'b1;
        if (status.last_voice) begin
          state_nxt = S_DONE;
        end
      end
      S_APPLY: begin
        ctrl.apply = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output beat pending flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[hdl/multichannel_stereo_pcm_mixer_unit.sv]
// Sixteen-voice stereo PCM mixer with per-voice volume and pan (top level).
// Sequence, taken beat to out_valid: a mix decodes, takes 16 voice steps and loads the result;
//   start and update run the 15-step serial gain divider before they apply; stop decodes, applies and loads.
// Flow: one command in flight; the next beat is taken the cycle after the result loads.
//   The output register lets it in while a result waits.
// Reset (rst_n, synchronous) idles all voices and sets the gain divisor to 16129.
`default_nettype none
module multichannel_stereo_pcm_mixer_unit
  import mspm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  // command channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_voice,
  input  wire logic [19:0] in_sound_length,
  input  wire logic [6:0]  in_volume,
  input  wire logic [7:0]  in_separation,
  input  wire logic [63:0] in_samples_low,
  input  wire logic [63:0] in_samples_high,
  // result channel
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic signed [15:0] out_mix_left,
  output logic signed [15:0] out_mix_right,
  output logic [15:0]        out_playing_mask
);

  dp_ctrl_t   ctrl_s;
  dp_status_t status_s;

  mspm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status_s),
    .ctrl      (ctrl_s)
  );

  mspm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl_s),
    .status           (status_s),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_voice         (in_voice),
    .in_sound_length  (in_sound_length),
    .in_volume        (in_volume),
    .in_separation    (in_separation),
    .in_samples_low   (in_samples_low),
    .in_samples_high  (in_samples_high),
    .out_mix_left     (out_mix_left),
    .out_mix_right    (out_mix_right),
    .out_playing_mask (out_playing_mask)
  );

  // A taken beat closes the input until its command is finished
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a command is in flight");

  // The dividers are never restarted mid-division
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_s.div_start |-> !status_s.div_busy)
    else $error("divider started while busy");

  // A result never overwrites a stalled beat
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_s.out_load |-> (!out_valid || !out_stall))
    else $error("output register loaded over a pending beat");

  // Voice stepping happens only for mix commands
  a_mix_only: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_s.mix_step |-> (status_s.cmd == CMD_MIX))
    else $error("voice step outside a mix command");

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the sixteen-voice stereo PCM mixer.
module tb
  import mspm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_BEATS = 150;
  localparam int IDLE_PCT    = 37;

  typedef struct {
    cmd_t        cmd;
    logic [3:0]  voice;
    logic [19:0] len;
    logic [6:0]  vol;
    logic [7:0]  sep;
    logic [63:0] lo;
    logic [63:0] hi;
  } beat_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        mask;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [3:0] in_voice = '0;
  logic [19:0] in_sound_length = '0;
  logic [6:0] in_volume = '0;
  logic [7:0] in_separation = '0;
  logic [63:0] in_samples_low = '0;
  logic [63:0] in_samples_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_mix_left;
  logic signed [15:0] out_mix_right;
  logic [15:0] out_playing_mask;

  // Idle switches for the command source and the result sink
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;

  int errors = 0;
  int cycles = 0;
  frame_t frames_due[$];
  frame_t want;

  // Predicted mixer state
  logic [15:0] cur_divisor = DIVISOR_RESET;
  logic        voice_live[VOICES] = '{default: 1'b0};
  logic [19:0] voice_pos[VOICES];
  logic [19:0] voice_len[VOICES];
  logic [7:0]  voice_gl[VOICES];
  logic [7:0]  voice_gr[VOICES];

  always #4 clk = ~clk;

  multichannel_stereo_pcm_mixer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_voice         (in_voice),
    .in_sound_length  (in_sound_length),
    .in_volume        (in_volume),
    .in_separation    (in_separation),
    .in_samples_low   (in_samples_low),
    .in_samples_high  (in_samples_high),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mix_left     (out_mix_left),
    .out_mix_right    (out_mix_right),
    .out_playing_mask (out_playing_mask)
  );

  // Per-side gain: volume times pan fraction over the divisor, clipped at 255
  function automatic logic [7:0] side_gain(logic [6:0] vol, logic [7:0] frac);
    int unsigned d;
    int unsigned g;
    d = (cur_divisor == 16'd0) ? 32'd1 : 32'(cur_divisor);
    g = (32'(vol) * 32'(frac)) / d;
    return (g > 32'(GAIN_MAX)) ? GAIN_MAX : g[7:0];
  endfunction

  function automatic void load_gains(logic [3:0] v, logic [6:0] vol, logic [7:0] sep_in);
    logic [7:0] sep;
    sep = (sep_in > PAN_FULL) ? PAN_FULL : sep_in;
    voice_gl[v] = side_gain(vol, PAN_FULL - sep);
    voice_gr[v] = side_gain(vol, sep);
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance the predicted state by one command and return the frame it yields
  function automatic frame_t predict_frame(beat_t b);
    frame_t f;
    int lsum;
    int rsum;
    int s;
    logic [7:0] smp;
    lsum = 0;
    rsum = 0;
    case (b.cmd)
      CMD_MIX: begin
        for (int c = 0; c < VOICES; c++) begin
          if (voice_live[c]) begin
            if (voice_pos[c] >= voice_len[c]) begin
              // end of sound: drop out unheard
              voice_live[c] = 1'b0;
            end else begin
              smp = (c < 8) ? b.lo[c*8 +: 8] : b.hi[(c-8)*8 +: 8];
              s = (int'(smp) - 128) * 256;
              voice_pos[c] = voice_pos[c] + 20'd1;
              lsum = sat16(lsum + (s * int'(voice_gl[c])) / 255);
              rsum = sat16(rsum + (s * int'(voice_gr[c])) / 255);
            end
          end
        end
      end
      CMD_START: begin
        voice_pos[b.voice] = '0;
        voice_len[b.voice] = b.len;
        load_gains(b.voice, b.vol, b.sep);
        voice_live[b.voice] = 1'b1;
      end
      CMD_STOP: voice_live[b.voice] = 1'b0;
      default: load_gains(b.voice, b.vol, b.sep);
    endcase
    f.left = lsum[15:0];
    f.right = rsum[15:0];
    for (int c = 0; c < VOICES; c++) f.mask[c] = voice_live[c];
    return f;
  endfunction

  // Present one beat, hold it until taken, then queue its expected frame
  task automatic send_beat(beat_t b);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= b.cmd;
    in_voice        <= b.voice;
    in_sound_length <= b.len;
    in_volume       <= b.vol;
    in_separation   <= b.sep;
    in_samples_low  <= b.lo;
    in_samples_high <= b.hi;
    do @(posedge clk); while (in_stall);
    frames_due.push_back(predict_frame(b));
  endtask

  task automatic send_cmd(cmd_t cmd, logic [3:0] voice, logic [19:0] len, logic [6:0] vol,
                          logic [7:0] sep, logic [63:0] lo, logic [63:0] hi);
    beat_t b;
    b = '{cmd: cmd, voice: voice, len: len, vol: vol, sep: sep, lo: lo, hi: hi};
    send_beat(b);
  endtask

  // Let the mixer drain, then write the gain divisor
  task automatic set_divisor(logic [15:0] val);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_divisor = val;
  endtask

  // Random command mix: short sounds dominate so voices keep ending
  function automatic beat_t rand_beat();
    beat_t b;
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(99);
    if (pick < 45) b.cmd = CMD_MIX;
    else if (pick < 72) b.cmd = CMD_START;
    else if (pick < 86) b.cmd = CMD_UPDATE;
    else b.cmd = CMD_STOP;
    b.voice = 4'($urandom_range(15));
    pick = $urandom_range(99);
    r = $urandom;
    if (pick < 70) b.len = 20'($urandom_range(12));
    else if (pick < 88) b.len = 20'($urandom_range(200));
    else if (pick < 96) b.len = r[19:0];
    else b.len = 20'hFFFFF;
    pick = $urandom_range(99);
    if (pick < 15) b.vol = 7'd127;
    else if (pick < 25) b.vol = 7'd0;
    else b.vol = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 10) b.sep = PAN_FULL;
    else if (pick < 20) b.sep = 8'd0;
    else b.sep = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 10) begin
      b.lo = '0;
      b.hi = '0;
    end else if (pick < 20) begin
      b.lo = '1;
      b.hi = '1;
    end else begin
      b.lo = {$urandom, $urandom};
      b.hi = {$urandom, $urandom};
    end
    return b;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_beat(rand_beat());
  endtask

  // Every command, end of sound, zero length, idle stop/update, pan clip,
  // restart of a live voice, and sum saturation both ways
  task automatic test_commands();
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '0, '0);
    send_cmd(CMD_START, 4'd0, 20'd2, 7'd127, 8'd0, '0, '0);
    send_cmd(CMD_START, 4'd15, 20'd0, 7'd127, 8'd254, '0, '0);
    send_cmd(CMD_START, 4'd7, 20'hFFFFF, 7'd0, 8'd255, '0, '0);
    send_cmd(CMD_UPDATE, 4'd3, 20'd0, 7'd127, 8'd127, '0, '0);
    send_cmd(CMD_STOP, 4'd5, 20'd0, 7'd0, 8'd0, '0, '0);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '0, '0);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '1, '1);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '1, '1);
    send_cmd(CMD_STOP, 4'd7, 20'd0, 7'd0, 8'd0, '0, '0);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '0, '0);
    set_divisor(16'd1);
    send_cmd(CMD_START, 4'd0, 20'd3, 7'd127, 8'd127, '0, '0);
    send_cmd(CMD_START, 4'd1, 20'd3, 7'd127, 8'd0, '0, '0);
    send_cmd(CMD_START, 4'd2, 20'd3, 7'd127, 8'd254, '0, '0);
    send_cmd(CMD_START, 4'd8, 20'd3, 7'd127, 8'd200, '0, '0);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '1, '1);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '0, '0);
    send_cmd(CMD_UPDATE, 4'd1, 20'd0, 7'd1, 8'd1, '0, '0);
    send_cmd(CMD_START, 4'd0, 20'd1, 7'd64, 8'd64, '0, '0);
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, {$urandom, $urandom}, {$urandom, $urandom});
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, {8{8'h80}}, {8{8'h80}});
    send_cmd(CMD_MIX, 4'd0, 20'd0, 7'd0, 8'd0, '1, '1);
  endtask

  // Largest divisor, zero divisor, and divisor one, which clips every gain whose product exceeds 255
  task automatic test_divisor_extremes();
    set_divisor(16'hFFFF);
    run_random(PHASE_BEATS);
    set_divisor(16'd0);
    run_random(PHASE_BEATS);
    set_divisor(16'd1);
    run_random(PHASE_BEATS);
  endtask

  task automatic test_random_traffic();
    set_divisor(DIVISOR_RESET);
    run_random(PHASE_BEATS);
    set_divisor(16'($urandom_range(65535, 1)));
    run_random(PHASE_BEATS);
    set_divisor(16'($urandom_range(300, 1)));
    run_random(PHASE_BEATS);
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    set_divisor(16'd127);
    run_random(PHASE_BEATS);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Random backpressure on the result channel
  always @(posedge clk) out_stall <= sink_idle_on && ($urandom_range(99) < IDLE_PCT);

  // Compare each result beat with the oldest expected frame
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with no expected frame, actual %0d %0d %0h", $time,
                 out_mix_left, out_mix_right, out_playing_mask);
      end else begin
        want = frames_due.pop_front();
        check_field("mix_left", int'(want.left), int'(out_mix_left));
        check_field("mix_right", int'(want.right), int'(out_mix_right));
        check_field("playing_mask", int'(want.mask), int'(out_playing_mask));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_divisor_extremes();
    test_random_traffic();
    test_back_to_back();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mspm_pkg.sv
hdl/mspm_div.sv
hdl/mspm_dp.sv
hdl/mspm_ctrl.sv
hdl/multichannel_stereo_pcm_mixer_unit.sv
sim/tb.sv
